FILE: src/sps_pkg.sv
// Shared types, codes and helper functions for the strobe pattern sequencer.
// Used by sps_divider, sps_core and strobe_pattern_sequencer; depends on nothing.
`default_nettype none

package sps_pkg;

    // Field and state widths
    localparam int LAMP_W     = 8;
    localparam int MODE_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 3;
    localparam int LEN_W      = 4;
    localparam int SEQ_W      = 24;
    localparam int TIME_W     = 16;
    localparam int PULSE_W    = 8;
    localparam int TABLE_W    = 28;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 28;
    localparam int ENTRY_W    = 3;
    localparam int MAX_LEN    = 8;

    // Phase time scaling: ms * 100 / speed, floor of 10
    localparam int SCALE_PCT     = 100;
    localparam int MIN_TIME      = 10;
    localparam int DOUBLE_PULSES = 2;
    localparam int QUO_W         = 23;
    localparam int SPEED_W       = 16;

    localparam int CHANNELS_DEF = 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    // Pattern modes
    localparam logic [MODE_W-1:0] MODE_SINGLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOUBLE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STROBE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ALTERN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEQUENCE = 3'd4;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ON    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_OFF   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MASK   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ON     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TABLE  = 3'd7;

    // Configuration reset values
    localparam logic [SPEED_W-1:0] SPEED_RST  = 16'd100;
    localparam logic [PULSE_W-1:0] REPEAT_RST = 8'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LAMP_W-1:0]  mask;
        logic [TIME_W-1:0]  on_ms;
        logic [TIME_W-1:0]  off_ms;
        logic [TIME_W-1:0]  pause_ms;
        logic [SPEED_W-1:0] speed;
        logic [PULSE_W-1:0] repeat_cnt;
        logic [TABLE_W-1:0] seq_table;
    } cfg_t;

    // Result word, lamps in the lowest bits
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [MODE_W-1:0]  active_mode;
        logic               running;
        logic [LAMP_W-1:0]  lamps;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
    } seq_tbl_t;

    // Compact the set bits of the mask into a channel list
    function automatic seq_tbl_t build_table(input logic [LAMP_W-1:0] mask);
        seq_tbl_t         t;
        logic [LEN_W-1:0] n;
        t.seq = '0;
        n     = '0;
        for (int i = 0; i < LAMP_W; i++) begin
            if (mask[i]) begin
                t.seq[ENTRY_W*n +: ENTRY_W] = ENTRY_W'(i);
                n = n + LEN_W'(1);
            end
        end
        t.len = n;
        return t;
    endfunction

    // Lamp drive after an on or off step
    function automatic logic [LAMP_W-1:0] apply_step(
        input logic [MODE_W-1:0] mode,
        input logic              on,
        input logic [LAMP_W-1:0] mask,
        input logic [SEQ_W-1:0]  seq,
        input logic [LEN_W-1:0]  len,
        input logic [IDX_W-1:0]  idx,
        input logic [LAMP_W-1:0] lamp_in,
        input logic [LAMP_W-1:0] lamp_bits,
        input logic [LEN_W-1:0]  channels
    );
        logic [ENTRY_W-1:0] ch;
        logic [LAMP_W-1:0]  lamp;
        ch = seq[ENTRY_W*idx +: ENTRY_W];
        if (mode <= MODE_STROBE) begin
            lamp = on ? (lamp_in | mask) : (lamp_in & ~mask);
            lamp = lamp & lamp_bits;
        end else begin
            lamp = '0;
            if (on && (len != '0) && ({1'b0, ch} < channels)) begin
                lamp[ch] = 1'b1;
            end
        end
        return lamp;
    endfunction

endpackage

`default_nettype wire

FILE: src/sps_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the three phase times.
// Depends on sps_pkg for widths.
`default_nettype none

module sps_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [sps_pkg::QUO_W-1:0]       dividend,
    input  wire logic [sps_pkg::SPEED_W-1:0]     divisor,
    output logic                                 done,
    output logic [sps_pkg::QUO_W-1:0]            quotient
);

    localparam int QuoW = sps_pkg::QUO_W;
    localparam int DivW = sps_pkg::SPEED_W;
    localparam int CntW = $clog2(QuoW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [QuoW-1:0] quo_reg, quo_next;
    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] dvs_reg, dvs_next;
    logic [DivW:0]   trial;

    // One restoring step per cycle while busy
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[QuoW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DivW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[QuoW-2:0], 1'b1};
            end else begin
                rem_next = trial[DivW-1:0];
                quo_next = {quo_reg[QuoW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(QuoW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // A new division never starts over one in flight
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    // Done follows the last step exactly
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finishing step");

    // The step counter stays within the quotient width
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg < CntW'(QuoW))
        else $error("divider step counter out of range");

endmodule

`default_nettype wire

FILE: src/sps_core.sv
// Pattern sequencer: command decode, phase timing and lamp stepping.
// Depends on sps_pkg and instantiates sps_divider for the phase time scaling.
`default_nettype none

module sps_core #(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sps_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sps_pkg::ACT_W-1:0]   in_action,
    input  wire logic                        in_all_off,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output sps_pkg::res_t                    out_res
);

    localparam int LampW  = sps_pkg::LAMP_W;
    localparam int TimeW  = sps_pkg::TIME_W;
    localparam int QuoW   = sps_pkg::QUO_W;
    localparam int SpeedW = sps_pkg::SPEED_W;
    localparam int LenW   = sps_pkg::LEN_W;
    localparam int IdxW   = sps_pkg::IDX_W;
    localparam int PulseW = sps_pkg::PULSE_W;
    localparam logic [LampW-1:0] LampBits = LampW'((9'd1 << CHANNELS) - 9'd1);
    localparam logic [LenW-1:0]  ChanCnt  = LenW'(CHANNELS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LAUNCH = 5'b00010,
        S_WAIT   = 5'b00100,
        S_EXEC   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [sps_pkg::ACT_W-1:0]   act_reg, act_next;
    logic                        clr_reg, clr_next;
    logic [1:0]                  div_idx_reg, div_idx_next;

    logic                        running_reg, running_next;
    logic [sps_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [TimeW-1:0]            elapsed_reg, elapsed_next;
    logic [PulseW-1:0]           pulse_reg, pulse_next;
    logic [IdxW-1:0]             seq_idx_reg, seq_idx_next;
    logic [LampW-1:0]            lamp_reg, lamp_next;
    logic [LenW-1:0]             len_reg, len_next;
    logic [sps_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [TimeW-1:0]            t_on_reg, t_on_next;
    logic [TimeW-1:0]            t_off_reg, t_off_next;
    logic [TimeW-1:0]            t_pause_reg, t_pause_next;
    logic [sps_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [LampW-1:0]            mask_reg, mask_next;
    logic [PulseW-1:0]           pulses_reg, pulses_next;

    logic                        div_start;
    logic                        div_done;
    logic [QuoW-1:0]             div_quo;
    logic [QuoW-1:0]             div_dividend;
    logic [SpeedW-1:0]           div_divisor;
    logic [TimeW-1:0]            div_ms;
    logic [TimeW-1:0]            scaled;

    logic                        start_ok;
    logic [LampW-1:0]            st_mask;
    logic [LenW-1:0]             st_len_cfg;
    sps_pkg::seq_tbl_t           st_tbl;
    sps_pkg::seq_tbl_t           dflt_tbl;
    logic [PulseW-1:0]           st_pulses;
    logic [TimeW-1:0]            el_inc;
    logic [PulseW-1:0]           pulse_inc;
    logic [LenW-1:0]             idx_inc;
    logic [IdxW-1:0]             idx_wrap;

    // Shared divider for the three phase times
    sps_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Operand select and time floor
    always_comb begin
        unique case (div_idx_reg)
            2'd0:    div_ms = cfg.on_ms;
            2'd1:    div_ms = cfg.off_ms;
            default: div_ms = cfg.pause_ms;
        endcase
        div_dividend = QuoW'({7'd0, div_ms} * QuoW'(sps_pkg::SCALE_PCT));
        div_divisor  = (cfg.speed == '0) ? SpeedW'(1) : cfg.speed;
        scaled       = (div_quo < QuoW'(sps_pkg::MIN_TIME)) ? TimeW'(sps_pkg::MIN_TIME)
                                                             : div_quo[TimeW-1:0];
    end

    // Snapshot values for a start
    always_comb begin
        start_ok   = (cfg.mode <= sps_pkg::MODE_SEQUENCE);
        st_mask    = cfg.mask & LampBits;
        st_len_cfg = cfg.seq_table[LenW-1:0];
        dflt_tbl   = sps_pkg::build_table(st_mask);
        if (st_len_cfg == '0) begin
            st_tbl = dflt_tbl;
        end else begin
            st_tbl.len = (st_len_cfg > LenW'(sps_pkg::MAX_LEN)) ? LenW'(sps_pkg::MAX_LEN)
                                                                : st_len_cfg;
            st_tbl.seq = cfg.seq_table[sps_pkg::TABLE_W-1:LenW];
        end
        if (cfg.mode == sps_pkg::MODE_DOUBLE) begin
            st_pulses = PulseW'(sps_pkg::DOUBLE_PULSES);
        end else if (cfg.mode >= sps_pkg::MODE_ALTERN) begin
            st_pulses = (st_tbl.len == '0) ? PulseW'(1) : PulseW'(st_tbl.len);
        end else begin
            st_pulses = (cfg.repeat_cnt == '0) ? PulseW'(1) : cfg.repeat_cnt;
        end
    end

    // Tick helpers
    always_comb begin
        el_inc    = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TimeW'(1);
        pulse_inc = pulse_reg + PulseW'(1);
        idx_inc   = {1'b0, seq_idx_reg} + LenW'(1);
        idx_wrap  = (idx_inc == len_reg) ? '0 : idx_inc[IdxW-1:0];
    end

    // Sequencer and pattern state update
    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        clr_next     = clr_reg;
        div_idx_next = div_idx_reg;
        running_next = running_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        pulse_next   = pulse_reg;
        seq_idx_next = seq_idx_reg;
        lamp_next    = lamp_reg;
        len_next     = len_reg;
        seq_next     = seq_reg;
        t_on_next    = t_on_reg;
        t_off_next   = t_off_reg;
        t_pause_next = t_pause_reg;
        mode_next    = mode_reg;
        mask_next    = mask_reg;
        pulses_next  = pulses_reg;
        div_start    = 1'b0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    act_next     = in_action;
                    clr_next     = in_all_off;
                    div_idx_next = 2'd0;
                    state_next   = (in_action == sps_pkg::ACT_START && start_ok)
                                   ? S_LAUNCH : S_EXEC;
                end
            end
            S_LAUNCH: begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    unique case (div_idx_reg)
                        2'd0:    t_on_next    = scaled;
                        2'd1:    t_off_next   = scaled;
                        default: t_pause_next = scaled;
                    endcase
                    if (div_idx_reg == 2'd2) begin
                        state_next = S_EXEC;
                    end else begin
                        div_idx_next = div_idx_reg + 2'd1;
                        state_next   = S_LAUNCH;
                    end
                end
            end
            S_EXEC: begin
                state_next = S_EMIT;
                unique case (act_reg)
                    sps_pkg::ACT_START: begin
                        if (start_ok) begin
                            mode_next    = cfg.mode;
                            mask_next    = st_mask;
                            len_next     = st_tbl.len;
                            seq_next     = st_tbl.seq;
                            pulses_next  = st_pulses;
                            phase_next   = sps_pkg::PH_ON;
                            elapsed_next = '0;
                            pulse_next   = '0;
                            seq_idx_next = '0;
                            running_next = 1'b1;
                            lamp_next    = sps_pkg::apply_step(cfg.mode, 1'b1, st_mask,
                                               st_tbl.seq, st_tbl.len, '0, lamp_reg,
                                               LampBits, ChanCnt);
                        end
                    end
                    sps_pkg::ACT_STOP: begin
                        running_next = 1'b0;
                        phase_next   = sps_pkg::PH_IDLE;
                        pulse_next   = '0;
                        seq_idx_next = '0;
                        elapsed_next = '0;
                        mode_next    = sps_pkg::MODE_SINGLE;
                        if (clr_reg) begin
                            lamp_next = '0;
                        end
                    end
                    sps_pkg::ACT_TICK: begin
                        if (running_reg) begin
                            elapsed_next = el_inc;
                            unique case (phase_reg)
                                sps_pkg::PH_ON: begin
                                    if (el_inc >= t_on_reg) begin
                                        lamp_next    = sps_pkg::apply_step(mode_reg, 1'b0,
                                                           mask_reg, seq_reg, len_reg,
                                                           seq_idx_reg, lamp_reg,
                                                           LampBits, ChanCnt);
                                        phase_next   = sps_pkg::PH_OFF;
                                        elapsed_next = '0;
                                    end
                                end
                                sps_pkg::PH_OFF: begin
                                    if (el_inc >= t_off_reg) begin
                                        elapsed_next = '0;
                                        if (pulse_inc >= pulses_reg) begin
                                            pulse_next = '0;
                                            phase_next = sps_pkg::PH_PAUSE;
                                        end else begin
                                            pulse_next = pulse_inc;
                                            if (len_reg != '0) begin
                                                seq_idx_next = idx_wrap;
                                            end
                                            lamp_next  = sps_pkg::apply_step(mode_reg,
                                                             1'b1, mask_reg, seq_reg,
                                                             len_reg,
                                                             (len_reg != '0) ? idx_wrap
                                                                             : seq_idx_reg,
                                                             lamp_reg, LampBits, ChanCnt);
                                            phase_next = sps_pkg::PH_ON;
                                        end
                                    end
                                end
                                sps_pkg::PH_PAUSE: begin
                                    if (el_inc >= t_pause_reg) begin
                                        if (mode_reg <= sps_pkg::MODE_DOUBLE) begin
                                            running_next = 1'b0;
                                            phase_next   = sps_pkg::PH_IDLE;
                                            pulse_next   = '0;
                                            seq_idx_next = '0;
                                            elapsed_next = '0;
                                            lamp_next    = '0;
                                            mode_next    = sps_pkg::MODE_SINGLE;
                                        end else begin
                                            seq_idx_next = '0;
                                            lamp_next    = sps_pkg::apply_step(mode_reg,
                                                               1'b1, mask_reg, seq_reg,
                                                               len_reg, '0, lamp_reg,
                                                               LampBits, ChanCnt);
                                            phase_next   = sps_pkg::PH_ON;
                                            elapsed_next = '0;
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            running_reg <= 1'b0;
            phase_reg   <= sps_pkg::PH_IDLE;
            elapsed_reg <= '0;
            pulse_reg   <= '0;
            seq_idx_reg <= '0;
            lamp_reg    <= '0;
            len_reg     <= '0;
            seq_reg     <= '0;
            t_on_reg    <= '0;
            t_off_reg   <= '0;
            t_pause_reg <= '0;
            mode_reg    <= sps_pkg::MODE_SINGLE;
            mask_reg    <= '0;
            pulses_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            pulse_reg   <= pulse_next;
            seq_idx_reg <= seq_idx_next;
            lamp_reg    <= lamp_next;
            len_reg     <= len_next;
            seq_reg     <= seq_next;
            t_on_reg    <= t_on_next;
            t_off_reg   <= t_off_next;
            t_pause_reg <= t_pause_next;
            mode_reg    <= mode_next;
            mask_reg    <= mask_next;
            pulses_reg  <= pulses_next;
        end
        act_reg     <= act_next;
        clr_reg     <= clr_next;
        div_idx_reg <= div_idx_next;
    end

    // Present the pattern state as the result word
    always_comb begin
        out_res.lamps       = lamp_reg;
        out_res.running     = running_reg;
        out_res.active_mode = running_reg ? mode_reg + sps_pkg::MODE_W'(1) : '0;
        out_res.phase       = phase_reg;
    end

    // Running and a non-idle phase go together
    a_run_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg == (phase_reg != sps_pkg::PH_IDLE))
        else $error("running flag and phase disagree");

    // Pulse count stays below the series length while running
    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (pulses_reg != '0) && (pulse_reg < pulses_reg))
        else $error("pulse count out of range");

    // Table index stays inside the table
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && len_reg != '0) |-> ({1'b0, seq_idx_reg} < len_reg))
        else $error("sequence index out of range");

    // Divider results arrive only while the sequencer waits for them
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_WAIT)
        else $error("divider result outside wait state");

    // A stalled result word stays put
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_res))
        else $error("result word changed while stalled");

endmodule

`default_nettype wire

FILE: src/strobe_pattern_sequencer.sv
// Strobe pattern sequencer top level: configuration registers, stream ports
// and output register. Depends on sps_pkg and instantiates sps_core.
//
// Each input word is a start, a stop or a one-millisecond tick (s_tuser) and
// yields exactly one result word with the lamp drive and pattern status. A
// stop, a tick or an unused action code passes through the execute and emit
// states before the next s_tready. A start with a valid mode first runs three
// phase-time divisions on one shared restoring divider, with s_tready low
// meanwhile. The result word sits in an output register, so a slow consumer
// holds the block only once the register is full. Configuration is sampled
// at start; writes during a run take effect at the next start.
`default_nettype none

module strobe_pattern_sequencer #(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [sps_pkg::CFG_ADDR_W-1:0]    cfg_wr_addr,
    input  wire logic [sps_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [0] all_off, [7:1] zero
    input  wire logic [1:0]                        s_tuser,   // [1:0] action
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata    // [7:0] lamps, [8] running,
                                                              // [11:9] active_mode,
                                                              // [13:12] phase, [15:14] zero
);

    sps_pkg::cfg_t cfg_reg, cfg_next;
    sps_pkg::res_t core_res;
    logic          core_out_valid;
    logic          core_out_ready;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;

    // Register file writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                sps_pkg::REG_MODE:   cfg_next.mode       = cfg_wr_data[sps_pkg::MODE_W-1:0];
                sps_pkg::REG_MASK:   cfg_next.mask       = cfg_wr_data[sps_pkg::LAMP_W-1:0];
                sps_pkg::REG_ON:     cfg_next.on_ms      = cfg_wr_data[sps_pkg::TIME_W-1:0];
                sps_pkg::REG_OFF:    cfg_next.off_ms     = cfg_wr_data[sps_pkg::TIME_W-1:0];
                sps_pkg::REG_PAUSE:  cfg_next.pause_ms   = cfg_wr_data[sps_pkg::TIME_W-1:0];
                sps_pkg::REG_SPEED:  cfg_next.speed      = cfg_wr_data[sps_pkg::SPEED_W-1:0];
                sps_pkg::REG_REPEAT: cfg_next.repeat_cnt = cfg_wr_data[sps_pkg::PULSE_W-1:0];
                sps_pkg::REG_TABLE:  cfg_next.seq_table  = cfg_wr_data[sps_pkg::TABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: '0, mask: '0, on_ms: '0, off_ms: '0, pause_ms: '0,
                         speed: sps_pkg::SPEED_RST, repeat_cnt: sps_pkg::REPEAT_RST,
                         seq_table: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sps_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_all_off (s_tdata[0]),
        .out_valid  (core_out_valid),
        .out_ready  (core_out_ready),
        .out_res    (core_res)
    );

    // Output register: load a finished word when empty or being drained
    assign core_out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_out_valid && core_out_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (core_out_valid && core_out_ready) begin
            m_tdata_reg <= {2'b00, core_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
